// File: rtl/srt_pkg.sv
// Shared constants, codes and types for the sorted region table.
package srt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int PAGE_SHIFT    = 12;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 48;
  localparam int PHYS_W   = 52;
  localparam int PAGES_W  = 24;
  localparam int TYPE_W   = 16;
  localparam int FLAGS_W  = 16;
  localparam int END_W    = ADDR_W + 1;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PHYS_W-1:0]  phys;
    logic [PAGES_W-1:0] pages;
    logic [TYPE_W-1:0]  kind;
    logic [FLAGS_W-1:0] bits;
  } entry_t;

  typedef struct packed {
    logic match;    // entry satisfies the search of the current operation
    logic overlap;  // entry base lies below the end of the region being inserted
  } cmp_t;

endpackage

// File: rtl/srt_table.sv
// Region storage: one write port, one registered read port.
module srt_table (
  input  logic                      clk,
  input  logic                      we,
  input  logic [srt_pkg::IDX_W-1:0] waddr,
  input  srt_pkg::entry_t           wdata,
  input  logic [srt_pkg::IDX_W-1:0] raddr,
  output srt_pkg::entry_t           rdata
);
  import srt_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/srt_cmp.sv
// Shared compare unit: tests one stored entry against the current key.
module srt_cmp (
  input  logic [srt_pkg::FUNC_W-1:0] func,
  input  srt_pkg::entry_t            ent,
  input  logic [srt_pkg::ADDR_W-1:0] key,
  input  logic [srt_pkg::END_W-1:0]  key_end,
  output srt_pkg::cmp_t              res
);
  import srt_pkg::*;

  logic [END_W-1:0] ent_base_x;
  logic [END_W-1:0] ent_end;

  assign ent_base_x = {1'b0, ent.base};
  assign ent_end    = ent_base_x + END_W'({ent.pages, {PAGE_SHIFT{1'b0}}});

  always_comb begin
    res         = '0;
    res.overlap = ent_base_x < key_end;
    unique case (func)
      FN_INSERT: res.match = ent.base >= key;
      FN_DELETE: res.match = ent.base == key;
      FN_FIND:   res.match = (ent.base <= key) && (ent_end > {1'b0, key});
      default:   res.match = 1'b0;
    endcase
  end

endmodule

// File: rtl/sorted_region_table.sv
// Top level of the sorted region table: sequencer, region storage and result register.
//
// Keeps up to 64 memory regions sorted by base address. Each input beat carries one
// operation: insert (refused with full status when the table holds 64 regions, or with
// overlap status when the first region at or above the new base starts below
// base + pages*4096), delete by exact base (not-found status on a miss), or find, which
// returns the first region covering the address. Every input beat gives one output beat.
// One operation runs at a time and in_stall stays high until its result is posted to the
// output register; a posted result may wait there while the next beat is accepted.
// The single read port of the region memory sets the pace, one stored entry per cycle: a
// scan reads the entries in order until one matches or all have been looked at. An insert
// that lands ahead of a stored region first shifts the entries above it up; an append is
// written directly from the scan. A delete of any entry but the last closes up the entries
// above the removed one; removing the last needs no move. The result is then posted to the
// output register. A refused full insert or an unused function code goes straight to posting.
module sorted_region_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srt_pkg::FUNC_W-1:0]    func,
  input  logic [srt_pkg::ADDR_W-1:0]    address,
  input  logic [srt_pkg::PHYS_W-1:0]    phys_address,
  input  logic [srt_pkg::PAGES_W-1:0]   page_count,
  input  logic [srt_pkg::TYPE_W-1:0]    region_type,
  input  logic [srt_pkg::FLAGS_W-1:0]   region_flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srt_pkg::STATUS_W-1:0]  status,
  output logic                          hit,
  output logic [srt_pkg::ADDR_W-1:0]    hit_base,
  output logic [srt_pkg::PHYS_W-1:0]    hit_phys,
  output logic [srt_pkg::PAGES_W-1:0]   hit_pages,
  output logic [srt_pkg::TYPE_W-1:0]    hit_type,
  output logic [srt_pkg::FLAGS_W-1:0]   hit_flags
);
  import srt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a beat
  localparam logic [1:0] S_SCAN = 2'd1;  // walking entries through the compare unit
  localparam logic [1:0] S_MOVE = 2'd2;  // shifting entries up (insert) or down (delete)
  localparam logic [1:0] S_FIN  = 2'd3;  // posting the result

  logic [1:0]          state, state_next;
  logic [FUNC_W-1:0]   op, op_next;
  entry_t              ent_new, ent_new_next;     // region carried by the beat
  logic [END_W-1:0]    key_end, key_end_next;     // base + pages*4096, full width
  logic [CNT_W-1:0]    count, count_next;

  // scan pipeline: ri is the next read address, ci the entry whose data is on rd_data
  logic [CNT_W-1:0]    ri, ri_next;
  logic                chk, chk_next;
  logic [IDX_W-1:0]    ci, ci_next;

  // move pipeline: read at mr, write the returned data at mw in the following cycle
  logic [IDX_W-1:0]    mr, mr_next;
  logic [IDX_W-1:0]    mw, mw_next;
  logic [IDX_W-1:0]    mend, mend_next;
  logic                mgo, mgo_next;
  logic                mv, mv_next;
  logic                mup, mup_next;
  logic [IDX_W-1:0]    pos, pos_next;

  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                res_hit, res_hit_next;
  entry_t              res_ent, res_ent_next;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  entry_t              rd_data;
  cmp_t                cmp;

  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    ci_p1;
  logic                out_load;

  srt_table u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  srt_cmp u_cmp (
    .func    (op),
    .ent     (rd_data),
    .key     (ent_new.base),
    .key_end (key_end),
    .res     (cmp)
  );

  assign in_stall = (state != S_IDLE);
  assign cnt_m1   = count - CNT_W'(1);
  assign ci_p1    = CNT_W'(ci) + CNT_W'(1);
  // result register frees up in the same cycle it is taken
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next      = state;
    op_next         = op;
    ent_new_next    = ent_new;
    key_end_next    = key_end;
    count_next      = count;
    ri_next         = ri;
    chk_next        = chk;
    ci_next         = ci;
    mr_next         = mr;
    mw_next         = mw;
    mend_next       = mend;
    mgo_next        = mgo;
    mv_next         = mv;
    mup_next        = mup;
    pos_next        = pos;
    res_status_next = res_status;
    res_hit_next    = res_hit;
    res_ent_next    = res_ent;
    mem_we          = 1'b0;
    mem_waddr       = mw;
    mem_wdata       = rd_data;
    mem_raddr       = ri[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next            = func;
          ent_new_next.base  = address;
          ent_new_next.phys  = phys_address;
          ent_new_next.pages = page_count;
          ent_new_next.kind  = region_type;
          ent_new_next.bits  = region_flags;
          key_end_next       = {1'b0, address} + END_W'({page_count, {PAGE_SHIFT{1'b0}}});
          ri_next            = '0;
          chk_next           = 1'b0;
          res_status_next    = ST_OK;
          res_hit_next       = 1'b0;
          res_ent_next       = '0;
          if (func == FN_INSERT && count == CNT_W'(TABLE_ENTRIES)) begin
            res_status_next = ST_FULL;
            state_next      = S_FIN;
          end else if (func == FN_NONE) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (chk && cmp.match) begin
          chk_next = 1'b0;
          case (op)
            FN_FIND: begin
              res_hit_next = 1'b1;
              res_ent_next = rd_data;
              state_next   = S_FIN;
            end
            FN_DELETE: begin
              count_next = cnt_m1;
              if (ci_p1 == count) begin
                state_next = S_FIN;    // last entry: nothing to close up
              end else begin
                mr_next    = ci_p1[IDX_W-1:0];
                mend_next  = cnt_m1[IDX_W-1:0];
                mup_next   = 1'b0;
                mgo_next   = 1'b1;
                mv_next    = 1'b0;
                state_next = S_MOVE;
              end
            end
            default: begin
              if (cmp.overlap) begin
                res_status_next = ST_OVERLAP;
                state_next      = S_FIN;
              end else begin
                pos_next   = ci;
                mr_next    = cnt_m1[IDX_W-1:0];
                mend_next  = ci;
                mup_next   = 1'b1;
                mgo_next   = 1'b1;
                mv_next    = 1'b0;
                state_next = S_MOVE;
              end
            end
          endcase
        end else if (ri == count) begin
          chk_next = 1'b0;
          if (op == FN_INSERT) begin
            // no successor: append
            mem_we     = 1'b1;
            mem_waddr  = count[IDX_W-1:0];
            mem_wdata  = ent_new;
            count_next = count + CNT_W'(1);
          end else if (op == FN_DELETE) begin
            res_status_next = ST_NOT_FOUND;
          end
          state_next = S_FIN;
        end else begin
          chk_next = 1'b1;
          ci_next  = ri[IDX_W-1:0];
          ri_next  = ri + CNT_W'(1);
        end
      end

      S_MOVE: begin
        mem_raddr = mr;
        if (mv) begin
          mem_we    = 1'b1;
          mem_waddr = mw;
          mem_wdata = rd_data;
        end
        if (mgo) begin
          mv_next = 1'b1;
          mw_next = mup ? mr + IDX_W'(1) : mr - IDX_W'(1);
          mr_next = mup ? mr - IDX_W'(1) : mr + IDX_W'(1);
          if (mr == mend) begin
            mgo_next = 1'b0;
          end
        end else begin
          mv_next = 1'b0;
          if (!mv) begin
            if (mup) begin
              // gap is open: drop the new region in
              mem_we     = 1'b1;
              mem_waddr  = pos;
              mem_wdata  = ent_new;
              count_next = count + CNT_W'(1);
            end
            state_next = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk       <= 1'b0;
      mgo       <= 1'b0;
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      chk   <= chk_next;
      mgo   <= mgo_next;
      mv    <= mv_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    ent_new    <= ent_new_next;
    key_end    <= key_end_next;
    ri         <= ri_next;
    ci         <= ci_next;
    mr         <= mr_next;
    mw         <= mw_next;
    mend       <= mend_next;
    mup        <= mup_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_hit    <= res_hit_next;
    res_ent    <= res_ent_next;
    if (out_load) begin
      status    <= res_status;
      hit       <= res_hit;
      hit_base  <= res_ent.base;
      hit_phys  <= res_ent.phys;
      hit_pages <= res_ent.pages;
      hit_type  <= res_ent.kind;
      hit_flags <= res_ent.bits;
    end
  end

endmodule
